[rtl/core/hsvrgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, constants, sector codes and the payload types between the stages.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned HUE_W = 16;
  localparam int unsigned SV_W  = 10;
  localparam int unsigned CH_W  = 8;

  localparam int unsigned DEG_FULL    = 360;
  localparam int unsigned DEG_SECTOR  = 60;
  localparam int unsigned ONE_Q8      = 256;
  localparam int unsigned Q_FULL      = ONE_Q8 * DEG_SECTOR;
  // A multiple of 360 that lifts every hue to a positive value.
  localparam int unsigned HUE_OFFSET  = DEG_FULL * 92;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_360   = (1 << RECIP_SHIFT) / DEG_FULL;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } hue_sector_e;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue_degrees;
    logic signed [SV_W-1:0]  saturation;
    logic signed [SV_W-1:0]  brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [8:0] sat;
    logic [8:0] val;
  } hue_red_t;

  typedef struct packed {
    hue_sector_e sector;
    logic [8:0]  p_num;
    logic [13:0] q_num;
    logic [13:0] t_num;
    logic [8:0]  val;
  } sect_mix_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

[rtl/core/hsvrgb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter channel interfaces
// Valid and ready handshake channels for the HSV input and the RGB result.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if
  import hsvrgb_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue_degrees;
  logic signed [SV_W-1:0]  saturation;
  logic signed [SV_W-1:0]  brightness;

  modport source (output valid, hue_degrees, saturation, brightness, input ready);
  modport sink   (input valid, hue_degrees, saturation, brightness, output ready);
endinterface

interface hsvrgb_out_if
  import hsvrgb_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[rtl/core/hsvrgb_hue_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB hue reduction
// Three stages: offset and clamp, reciprocal quotient, remainder correction.
// ----------------------------------------------------------------------------
module hsvrgb_hue_reduce
  import hsvrgb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hsv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hue_red_t out_data_o
);

  typedef struct packed {
    logic [16:0] hue_off;
    logic [8:0]  sat;
    logic [8:0]  val;
  } norm_t;

  typedef struct packed {
    logic [16:0] hue_off;
    logic [7:0]  quo;
    logic [8:0]  sat;
    logic [8:0]  val;
  } quot_t;

  logic     s1_valid_q, s2_valid_q, s3_valid_q;
  logic     s1_ready, s2_ready, s3_ready;
  norm_t    s1_d, s1_q;
  quot_t    s2_d, s2_q;
  hue_red_t s3_d, s3_q;

  logic signed [17:0] hue_sum;
  logic [32:0]        quo_prod;
  logic [16:0]        quo_mul;
  logic [16:0]        rem_raw;

  function automatic logic [8:0] clamp_unit(logic signed [SV_W-1:0] x);
    logic [8:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed(SV_W'(ONE_Q8))) begin
      res = 9'(ONE_Q8);
    end else begin
      res = x[8:0];
    end
    return res;
  endfunction

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    hue_sum      = 18'(in_data_i.hue_degrees) + $signed(18'(HUE_OFFSET));
    s1_d.hue_off = hue_sum[16:0];
    s1_d.sat     = clamp_unit(in_data_i.saturation);
    s1_d.val     = clamp_unit(in_data_i.brightness);
  end

  always_comb begin
    quo_prod     = 33'(s1_q.hue_off) * 33'(RECIP_360);
    s2_d.hue_off = s1_q.hue_off;
    s2_d.quo     = quo_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    s2_d.sat     = s1_q.sat;
    s2_d.val     = s1_q.val;
  end

  // The quotient estimate is low by at most one, so one correction suffices.
  always_comb begin
    quo_mul = 17'(s2_q.quo) * 17'(DEG_FULL);
    rem_raw = s2_q.hue_off - quo_mul;
    if (rem_raw >= 17'(DEG_FULL)) begin
      s3_d.hue = 9'(rem_raw - 17'(DEG_FULL));
    end else begin
      s3_d.hue = rem_raw[8:0];
    end
    s3_d.sat = s2_q.sat;
    s3_d.val = s2_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

`ifndef SYNTH
  a_hue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_q.hue < 9'(DEG_FULL)))
    else $error("Reduced hue is not below a full turn.");
`endif

endmodule

[rtl/core/hsvrgb_sector_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB sector split and saturation mix
// Two stages: sector and remainder, then the p, q and t numerators.
// ----------------------------------------------------------------------------
module hsvrgb_sector_mix
  import hsvrgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hue_red_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sect_mix_t out_data_o
);

  typedef struct packed {
    hue_sector_e sector;
    logic [5:0]  rem;
    logic [8:0]  sat;
    logic [8:0]  val;
  } split_t;

  logic      s1_valid_q, s2_valid_q;
  logic      s1_ready, s2_ready;
  split_t    s1_d, s1_q;
  sect_mix_t s2_d, s2_q;

  logic [8:0]  base;
  logic [8:0]  rem_full;
  logic [5:0]  rem_inv;
  logic [14:0] sat_rem;
  logic [14:0] sat_inv;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    if (in_data_i.hue >= 9'(5 * DEG_SECTOR)) begin
      s1_d.sector = SECT_MAGENTA;
    end else if (in_data_i.hue >= 9'(4 * DEG_SECTOR)) begin
      s1_d.sector = SECT_BLUE;
    end else if (in_data_i.hue >= 9'(3 * DEG_SECTOR)) begin
      s1_d.sector = SECT_CYAN;
    end else if (in_data_i.hue >= 9'(2 * DEG_SECTOR)) begin
      s1_d.sector = SECT_GREEN;
    end else if (in_data_i.hue >= 9'(DEG_SECTOR)) begin
      s1_d.sector = SECT_YELLOW;
    end else begin
      s1_d.sector = SECT_RED;
    end
    case (s1_d.sector)
      SECT_YELLOW:  base = 9'(DEG_SECTOR);
      SECT_GREEN:   base = 9'(2 * DEG_SECTOR);
      SECT_CYAN:    base = 9'(3 * DEG_SECTOR);
      SECT_BLUE:    base = 9'(4 * DEG_SECTOR);
      SECT_MAGENTA: base = 9'(5 * DEG_SECTOR);
      default:      base = '0;
    endcase
    rem_full  = in_data_i.hue - base;
    s1_d.rem  = rem_full[5:0];
    s1_d.sat  = in_data_i.sat;
    s1_d.val  = in_data_i.val;
  end

  always_comb begin
    rem_inv     = 6'(DEG_SECTOR) - s1_q.rem;
    sat_rem     = 15'(s1_q.sat) * 15'(s1_q.rem);
    sat_inv     = 15'(s1_q.sat) * 15'(rem_inv);
    s2_d.sector = s1_q.sector;
    s2_d.p_num  = 9'(ONE_Q8) - s1_q.sat;
    s2_d.q_num  = 14'(15'(Q_FULL) - sat_rem);
    s2_d.t_num  = 14'(15'(Q_FULL) - sat_inv);
    s2_d.val    = s1_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

`ifndef SYNTH
  a_rem_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_q.rem < 6'(DEG_SECTOR)))
    else $error("Hue remainder is not below one sector.");
`endif

endmodule

[rtl/core/hsvrgb_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB channel scaling and selection
// Two stages: value products, then scaling by 255 and the sector swizzle.
// ----------------------------------------------------------------------------
module hsvrgb_channel
  import hsvrgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sect_mix_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rgb_t      out_data_o
);

  typedef struct packed {
    hue_sector_e     sector;
    logic [17:0]     x_p;
    logic [21:0]     x_q;
    logic [21:0]     x_t;
    logic [CH_W-1:0] v_ch;
  } prod_t;

  logic  s1_valid_q, s2_valid_q;
  logic  s1_ready, s2_ready;
  prod_t s1_d, s1_q;
  rgb_t  s2_d, s2_q;

  logic [16:0]     v_scaled;
  logic [25:0]     p_scaled;
  logic [25:0]     q_scaled;
  logic [25:0]     t_scaled;
  logic [CH_W-1:0] p_ch, q_ch, t_ch;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    v_scaled    = 17'({in_data_i.val, 8'h00}) - 17'(in_data_i.val);
    s1_d.sector = in_data_i.sector;
    s1_d.x_p    = 18'(in_data_i.val) * 18'(in_data_i.p_num);
    s1_d.x_q    = 22'(in_data_i.val) * 22'(in_data_i.q_num);
    s1_d.x_t    = 22'(in_data_i.val) * 22'(in_data_i.t_num);
    s1_d.v_ch   = v_scaled[15:8];
  end

  // Times 255 over 2^16 for p, and times 255 over 2^18 * 15 (that is 17 over
  // 2^18) for q and t.
  always_comb begin
    p_scaled = 26'({s1_q.x_p, 8'h00}) - 26'(s1_q.x_p);
    q_scaled = 26'({s1_q.x_q, 4'h0}) + 26'(s1_q.x_q);
    t_scaled = 26'({s1_q.x_t, 4'h0}) + 26'(s1_q.x_t);
    p_ch     = p_scaled[23:16];
    q_ch     = q_scaled[25:18];
    t_ch     = t_scaled[25:18];
    case (s1_q.sector)
      SECT_YELLOW:  s2_d = '{red: q_ch,      green: s1_q.v_ch, blue: p_ch};
      SECT_GREEN:   s2_d = '{red: p_ch,      green: s1_q.v_ch, blue: t_ch};
      SECT_CYAN:    s2_d = '{red: p_ch,      green: q_ch,      blue: s1_q.v_ch};
      SECT_BLUE:    s2_d = '{red: t_ch,      green: p_ch,      blue: s1_q.v_ch};
      SECT_MAGENTA: s2_d = '{red: s1_q.v_ch, green: p_ch,      blue: q_ch};
      default:      s2_d = '{red: s1_q.v_ch, green: t_ch,      blue: p_ch};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

`ifndef SYNTH
  a_comp_below_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (p_ch <= s1_q.v_ch) && (q_ch <= s1_q.v_ch) && (t_ch <= s1_q.v_ch))
    else $error("A mixed component exceeds the value component.");
  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_ready_i) |=> s2_valid_q && $stable(s2_q))
    else $error("A stalled result was lost or changed.");
`endif

endmodule

[rtl/core/hsv_to_rgb_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts a signed hue with Q2.8 saturation and value into an 8-bit RGB
// triple through a seven-stage pipeline.
//
//   Channel  Direction  Handshake      Payload
//   hsv_i    in         valid / ready  hue_degrees, saturation, brightness
//   rgb_o    out        valid / ready  red, green, blue
//
// One transfer is accepted every clock cycle while the output is taken.
// Each result passes through the stages in order: hue reduction (three),
// sector split and mix (two), scaling (two).
// Reset clears the stage valid bits only; no clearing pass is needed.
// Each stage holds its item while the next one is full, so a stall on the
// output fills the bubbles before the input is held off.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
  import hsvrgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvrgb_in_if.sink   hsv_i,
  hsvrgb_out_if.source rgb_o
);

  hsv_in_t   in_data;
  hue_red_t  red_data;
  sect_mix_t mix_data;
  rgb_t      out_data;
  logic      red_valid, red_ready;
  logic      mix_valid, mix_ready;

  assign in_data = '{hue_degrees: hsv_i.hue_degrees,
                     saturation:  hsv_i.saturation,
                     brightness:  hsv_i.brightness};

  hsvrgb_hue_reduce u_hue_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsv_i.valid),
    .in_ready_o  (hsv_i.ready),
    .in_data_i   (in_data),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .out_data_o  (red_data)
  );

  hsvrgb_sector_mix u_sector_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .in_data_i   (red_data),
    .out_valid_o (mix_valid),
    .out_ready_i (mix_ready),
    .out_data_o  (mix_data)
  );

  hsvrgb_channel u_channel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (mix_ready),
    .in_data_i   (mix_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (out_data)
  );

  assign rgb_o.red   = out_data.red;
  assign rgb_o.green = out_data.green;
  assign rgb_o.blue  = out_data.blue;

endmodule
